// ----- rtl/assert_macros.svh -----
// Assertion macros used by the top level of the address classifier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// General clocked property, disabled while reset is asserted.
`define ASSERT_PROP(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Overlapping implication from an antecedent to a consequent.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  `ASSERT_PROP(lbl, clk, rst_n, (ante) |-> (cons), msg)

`endif

// ----- rtl/ipnc_pkg.sv -----
// Types and constants shared by the address classifier modules.
package ipnc_pkg;

  typedef struct packed {
    logic [63:0] addr_hi;
    logic [63:0] addr_lo;
  } in_word_t;

  typedef struct packed {
    logic        is_valid;
    logic        is_local;
    logic        is_multicast;
    logic        is_routable;
    logic [7:0]  group_class;
    logic [2:0]  group_len;
    logic [39:0] group_bytes;
  } out_word_t;

  // Network-group class codes.
  localparam logic [7:0] CLASS_UNROUTABLE = 8'd0;
  localparam logic [7:0] CLASS_IPV4       = 8'd1;
  localparam logic [7:0] CLASS_IPV6       = 8'd2;
  localparam logic [7:0] CLASS_ONION      = 8'd3;

  // Key lengths in bytes.
  localparam logic [2:0] LEN_NONE  = 3'd0;
  localparam logic [2:0] LEN_ONION = 3'd1;
  localparam logic [2:0] LEN_IPV4  = 3'd2;
  localparam logic [2:0] LEN_IPV6  = 3'd4;
  localparam logic [2:0] LEN_PROV  = 3'd5;

  // Onion service prefix, first six address bytes.
  localparam logic [47:0] ONION_PFX = 48'hFD87_D87E_EB43;

endpackage

// ----- rtl/ipnc_classify.sv -----
// Combinational range checks and network-group key selection for one address.
module ipnc_classify (
  input  ipnc_pkg::in_word_t  in_word,
  input  logic                allow_private_net,
  output ipnc_pkg::out_word_t out_word
);

  logic [127:0] a;
  logic [7:0]   r [16];
  logic         v4, tor, local_addr, mcast, valid, bad, routable;
  logic         siit, nat64, six_to_four, teredo, provider;
  logic [7:0]   k [5];
  logic [7:0]   cls;
  logic [2:0]   len;

  assign a = {in_word.addr_hi, in_word.addr_lo};

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      r[i] = a[127 - 8*i -: 8];
    end
  end

  assign v4  = (a[127:48] == 80'd0) && (a[47:32] == 16'hFFFF);
  assign tor = (a[127:80] == ipnc_pkg::ONION_PFX);

  assign local_addr = (v4 && (r[12] == 8'd127 || r[12] == 8'd0)) ||
                      (a[127:8] == 120'd0 && r[15] == 8'd1);
  assign mcast      = (v4 && r[12][7:4] == 4'hE) || (r[0] == 8'hFF);

  // Shifted-mapped garbage, unspecified, documentation and the two IPv4 edge values.
  assign valid = !(a[127:72] == 56'd0 && r[7] == 8'hFF && r[8] == 8'hFF) &&
                 (a != 128'd0) &&
                 (a[127:96] != 32'h2001_0DB8) &&
                 !(v4 && (a[31:0] == 32'hFFFF_FFFF || a[31:0] == 32'd0));

  always_comb begin
    bad = 1'b0;
    if (!allow_private_net && v4 &&
        (r[12] == 8'd10 || (r[12] == 8'd192 && r[13] == 8'd168) ||
         (r[12] == 8'd172 && (r[13] inside {[8'd16:8'd31]})))) begin
      bad = 1'b1;
    end
    if (v4 && r[12] == 8'd198 && (r[13] inside {8'd18, 8'd19})) begin
      bad = 1'b1;
    end
    if (v4 && r[12] == 8'd169 && r[13] == 8'd254) begin
      bad = 1'b1;
    end
    if (a[127:112] == 16'hFE80 && a[111:64] == 48'd0) begin
      bad = 1'b1;
    end
    if (v4 && r[12] == 8'd100 && (r[13] inside {[8'd64:8'd127]})) begin
      bad = 1'b1;
    end
    if (v4 && ((r[12] == 8'd192 && r[13] == 8'd0 && r[14] == 8'd2) ||
               (r[12] == 8'd198 && r[13] == 8'd51 && r[14] == 8'd100) ||
               (r[12] == 8'd203 && r[13] == 8'd0 && r[14] == 8'd113))) begin
      bad = 1'b1;
    end
    if (r[0][7:1] == 7'b1111_110 && !tor) begin
      bad = 1'b1;
    end
    if (a[127:104] == 24'h20_0100 && r[3][7:4] == 4'h1) begin
      bad = 1'b1;
    end
    if (local_addr) begin
      bad = 1'b1;
    end
  end

  assign routable = valid && !bad;

  assign siit        = (a[127:64] == 64'd0) && (a[63:32] == 32'hFFFF_0000);
  assign nat64       = (a[127:96] == 32'h0064_FF9B) && (a[95:32] == 64'd0);
  assign six_to_four = (a[127:112] == 16'h2002);
  assign teredo      = (a[127:96] == 32'h2001_0000);
  assign provider    = (a[127:96] == 32'h2001_0470);

  always_comb begin
    cls = ipnc_pkg::CLASS_UNROUTABLE;
    len = ipnc_pkg::LEN_NONE;
    for (int i = 0; i < 5; i++) begin
      k[i] = 8'd0;
    end
    if (!routable) begin
      cls = ipnc_pkg::CLASS_UNROUTABLE;
    end else if (v4 || siit || nat64) begin
      cls  = ipnc_pkg::CLASS_IPV4;
      len  = ipnc_pkg::LEN_IPV4;
      k[0] = r[12];
      k[1] = r[13];
    end else if (six_to_four) begin
      cls  = ipnc_pkg::CLASS_IPV4;
      len  = ipnc_pkg::LEN_IPV4;
      k[0] = r[2];
      k[1] = r[3];
    end else if (teredo) begin
      // Teredo carries the client's IPv4 address inverted.
      cls  = ipnc_pkg::CLASS_IPV4;
      len  = ipnc_pkg::LEN_IPV4;
      k[0] = ~r[12];
      k[1] = ~r[13];
    end else if (tor) begin
      cls  = ipnc_pkg::CLASS_ONION;
      len  = ipnc_pkg::LEN_ONION;
      k[0] = r[6] | 8'h0F;
    end else begin
      cls = ipnc_pkg::CLASS_IPV6;
      len = ipnc_pkg::LEN_IPV6;
      for (int i = 0; i < 4; i++) begin
        k[i] = r[i];
      end
      if (provider) begin
        len  = ipnc_pkg::LEN_PROV;
        k[4] = r[4] | 8'h0F;
      end
    end
  end

  assign out_word.is_valid     = valid;
  assign out_word.is_local     = local_addr;
  assign out_word.is_multicast = mcast;
  assign out_word.is_routable  = routable;
  assign out_word.group_class  = cls;
  assign out_word.group_len    = len;
  assign out_word.group_bytes  = {k[0], k[1], k[2], k[3], k[4]};

endmodule

// ----- rtl/ip_address_netgroup_classifier.sv -----
// Top level of the IPv6 address classifier with network-group key.
// Usage:
//   Input channel: drive in_data with an address and pulse start. A word is
//   taken at every rising edge where start is high and busy is low; busy is
//   never raised, so one address can be taken in every cycle.
//   Result channel: out_valid is high for exactly one cycle with the
//   classification on out_data. The receiver cannot hold results off.
//   From the accepting edge to the edge that takes the result, a word passes
//   one input register, the range checks and one result register.
//   Throughput is one address per cycle, set by the single registered pass.
//   Configuration: cfg_ready is always high; cfg_data sets allow_private_net,
//   which lets RFC1918 IPv4 ranges count as routable. Write it only while no
//   address is in flight.
//   Reset: rst_n low clears both stages' valid flags and the configuration
//   register to zero; words in flight are dropped.
module ip_address_netgroup_classifier (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ipnc_pkg::in_word_t  in_data,
  output logic                out_valid,
  output ipnc_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_data
);

  `include "assert_macros.svh"

  logic                in_valid_r, in_valid_nxt;
  ipnc_pkg::in_word_t  in_word_r;
  logic                out_valid_r, out_valid_nxt;
  ipnc_pkg::out_word_t out_word_r, out_word_nxt;
  logic                allow_private_net_r, allow_private_net_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  assign in_valid_nxt          = start && !busy;
  assign out_valid_nxt         = in_valid_r;
  assign allow_private_net_nxt = (cfg_valid && cfg_ready) ? cfg_data : allow_private_net_r;

  ipnc_classify u_classify (
    .in_word           (in_word_r),
    .allow_private_net (allow_private_net_r),
    .out_word          (out_word_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r          <= 1'b0;
      out_valid_r         <= 1'b0;
      allow_private_net_r <= 1'b0;
    end else begin
      in_valid_r          <= in_valid_nxt;
      out_valid_r         <= out_valid_nxt;
      allow_private_net_r <= allow_private_net_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid_nxt) begin
      in_word_r <= in_data;
    end
    if (out_valid_nxt) begin
      out_word_r <= out_word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // Every accepted word yields a result from the result register.
  `ASSERT_IMPL(a_result_follows, clk, rst_n, start && !busy, ##2 out_valid, "accepted word lost")
  // An unroutable result carries an empty key.
  `ASSERT_IMPL(a_unroutable_key, clk, rst_n, out_valid && !out_data.is_routable, (out_data.group_class == ipnc_pkg::CLASS_UNROUTABLE) && (out_data.group_len == ipnc_pkg::LEN_NONE) && (out_data.group_bytes == 40'd0), "unroutable result has a key")
  // Routable implies valid and not local.
  `ASSERT_IMPL(a_routable_flags, clk, rst_n, out_valid && out_data.is_routable, out_data.is_valid && !out_data.is_local, "routable flag inconsistent")
  // A one-byte key only comes from the onion prefix.
  `ASSERT_IMPL(a_onion_len, clk, rst_n, out_valid && (out_data.group_len == ipnc_pkg::LEN_ONION), out_data.group_class == ipnc_pkg::CLASS_ONION, "one-byte key outside onion class")

endmodule
